### rtl/rte_pkg.sv
// shared types, constants and angle helpers for the rotation matrix to euler block
// no dependencies

package rte_pkg;

    localparam int          IN_W        = 16;
    localparam int          OUT_W       = 16;
    localparam int          TOL_W       = 11;
    localparam int          ONE_Q14     = 16384;
    localparam int          ARG_W       = 17;
    localparam int          SQ_N_W      = 29;
    localparam int          SQ_R_W      = 30;
    localparam int          SQ_CELLS    = 15;
    localparam int          SCALE_SHIFT = 16;
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam int          DEF_ANGLE_FRACTION_BITS = 13;
    localparam int          DEF_CORDIC_STAGES       = 16;

    // operands that travel beside the square root cells
    typedef struct packed {
        logic                    valid;
        logic                    lock;
        logic                    m31_neg;
        logic signed [IN_W-1:0]  m11;
        logic signed [IN_W-1:0]  m12;
        logic signed [IN_W-1:0]  m13;
        logic signed [IN_W-1:0]  m21;
        logic signed [IN_W-1:0]  m32;
        logic signed [IN_W-1:0]  m33;
        logic signed [IN_W-1:0]  xc;
    } t_side;

    // control that travels beside the cordic cells
    typedef struct packed {
        logic valid;
        logic lock;
        logic m31_neg;
    } t_tail;

    function automatic logic [32:0] from_q30(logic [32:0] q, int f);
        logic [32:0] t;
        t = (q >> (29 - f)) + 33'd1;
        return t >> 1;
    endfunction

    function automatic logic [32:0] stage_angle(int i, int f);
        logic [32:0] raw;
        case (i)
            0:       raw = 33'd843314856;
            1:       raw = 33'd497837829;
            2:       raw = 33'd263043836;
            3:       raw = 33'd133525158;
            4:       raw = 33'd67021686;
            5:       raw = 33'd33543515;
            6:       raw = 33'd16775850;
            7:       raw = 33'd8388437;
            8:       raw = 33'd4194282;
            9:       raw = 33'd2097149;
            10:      raw = 33'd1048575;
            default: begin
                if (i <= 30) raw = (33'd1 << (30 - i)) - 33'd1;
                else         raw = 33'd0;
            end
        endcase
        return from_q30(raw, f);
    endfunction

endpackage

### rtl/rte_isqrt_cell.sv
// one digit cell of the pipelined floor square root
// depends on rte_pkg

module rte_isqrt_cell #(
    parameter int K = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rte_pkg::SQ_N_W-1:0]    i_n,
    input  logic [rte_pkg::SQ_R_W-1:0]    i_r,
    output logic [rte_pkg::SQ_N_W-1:0]    o_n,
    output logic [rte_pkg::SQ_R_W-1:0]    o_r
);

    localparam logic [rte_pkg::SQ_R_W:0] Bit = (rte_pkg::SQ_R_W+1)'(1) << (28 - 2 * K);

    logic [rte_pkg::SQ_R_W:0]   w_sum;
    logic                       w_take;
    logic [rte_pkg::SQ_N_W-1:0] n_n;
    logic [rte_pkg::SQ_R_W-1:0] n_r;
    logic [rte_pkg::SQ_N_W-1:0] r_n;
    logic [rte_pkg::SQ_R_W-1:0] r_r;

    always_comb begin
        w_sum  = {1'b0, i_r} + Bit;
        w_take = {2'b00, i_n} >= w_sum;
        if (w_take) begin
            n_n = rte_pkg::SQ_N_W'({2'b00, i_n} - w_sum);
            n_r = rte_pkg::SQ_R_W'({2'b00, i_r[rte_pkg::SQ_R_W-1:1]} + Bit);
        end else begin
            n_n = i_n;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= n_n;
            r_r <= n_r;
        end
    end

    assign o_n = r_n;
    assign o_r = r_r;

endmodule

### rtl/rte_cordic_pre.sv
// axis cases and half plane fold ahead of a cordic vectoring chain
// depends on rte_pkg

module rte_cordic_pre #(
    parameter int F  = 13,
    parameter int XW = 36,
    parameter int ZW = 17
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [rte_pkg::ARG_W-1:0]  i_y,
    input  logic signed [rte_pkg::ARG_W-1:0]  i_x,
    output logic signed [XW-1:0]              o_x,
    output logic signed [XW-1:0]              o_y,
    output logic signed [ZW-1:0]              o_z,
    output logic                              o_spec,
    output logic signed [ZW-1:0]              o_spval
);

    localparam logic signed [ZW-1:0] Pi = ZW'(rte_pkg::from_q30(rte_pkg::PI_Q30, F));
    localparam logic signed [ZW-1:0] Hp = ZW'(rte_pkg::from_q30(rte_pkg::HALF_PI_Q30, F));

    logic signed [XW-1:0] n_x, n_y, r_x, r_y;
    logic signed [ZW-1:0] n_z, n_spval, r_z, r_spval;
    logic                 n_spec, r_spec;
    logic signed [rte_pkg::ARG_W-1:0] w_x, w_y;

    always_comb begin
        n_spec  = (i_y == '0) || (i_x == '0);
        if (i_y == '0) n_spval = (i_x < 0) ? Pi : '0;
        else           n_spval = (i_y > 0) ? Hp : -Hp;
        if (i_x < 0) begin
            n_z = (i_y > 0) ? Pi : -Pi;
            w_x = -i_x;
            w_y = -i_y;
        end else begin
            n_z = '0;
            w_x = i_x;
            w_y = i_y;
        end
        n_x = XW'(w_x) <<< rte_pkg::SCALE_SHIFT;
        n_y = XW'(w_y) <<< rte_pkg::SCALE_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_spec  <= n_spec;
            r_spval <= n_spval;
        end
    end

    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_spec  = r_spec;
    assign o_spval = r_spval;

endmodule

### rtl/rte_cordic_cell.sv
// one micro rotation cell of a cordic vectoring chain
// depends on rte_pkg

module rte_cordic_cell #(
    parameter int S  = 0,
    parameter int F  = 13,
    parameter int XW = 36,
    parameter int ZW = 17
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic                 i_spec,
    input  logic signed [ZW-1:0] i_spval,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic                 o_spec,
    output logic signed [ZW-1:0] o_spval
);

    localparam logic signed [ZW-1:0] Ang = ZW'(rte_pkg::stage_angle(S, F));

    logic signed [XW-1:0] w_dx, w_dy, n_x, n_y, r_x, r_y;
    logic signed [ZW-1:0] n_z, r_z, r_spval;
    logic                 r_spec;

    always_comb begin
        w_dx = i_y >>> S;
        w_dy = i_x >>> S;
        if (i_y > 0) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + Ang;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - Ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_spec  <= i_spec;
            r_spval <= i_spval;
        end
    end

    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_spec  = r_spec;
    assign o_spval = r_spval;

endmodule

### rtl/rotation_matrix_to_euler_xyz.sv
// rotation matrix to roll / pitch / yaw, top level
// depends on rte_pkg, rte_isqrt_cell, rte_cordic_pre, rte_cordic_cell
//
// usage
// - input channel i_valid / o_stall carries seven q2.14 matrix entries; a
//   transaction completes at a clock edge with i_valid high and o_stall low
// - output channel o_valid / i_stall returns roll, pitch, yaw (q3.13 by
//   default) and the gimbal lock flag, one result transaction per input
// - config channel i_cfg_valid / o_cfg_ready writes the gimbal tolerance;
//   ready is always high, write only while the block is idle
// - the pipe registers are the input register, square root
//   operand, 15 square root digit cells, cordic fold, the cordic cells and
//   the output register; one matrix per cycle is accepted when not stalled
// - five cordic chains run side by side (asin, two roll candidates, two
//   yaw candidates), the gimbal atan2 shares the first roll chain
// - when the receiver stalls a waiting result, the whole pipe holds and
//   o_stall follows, so the waiting result stays put and nothing is dropped
// - reset clears all valid bits and sets the tolerance to zero

module rotation_matrix_to_euler_xyz #(
    parameter int ANGLE_FRACTION_BITS = rte_pkg::DEF_ANGLE_FRACTION_BITS,
    parameter int CORDIC_STAGES       = rte_pkg::DEF_CORDIC_STAGES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m11,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m12,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m13,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m21,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m31,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m32,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m33,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [rte_pkg::OUT_W-1:0]  o_roll,
    output logic signed [rte_pkg::OUT_W-1:0]  o_pitch,
    output logic signed [rte_pkg::OUT_W-1:0]  o_yaw,
    output logic                              o_gimbal_lock,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rte_pkg::TOL_W-1:0]         i_cfg_gimbal_tolerance
);

    localparam int F   = ANGLE_FRACTION_BITS;
    localparam int CS  = CORDIC_STAGES;
    localparam int XW  = 36;
    localparam int ZW  = F + 4;
    localparam int NCH = 5;
    localparam logic signed [ZW-1:0] Pi = ZW'(rte_pkg::from_q30(rte_pkg::PI_Q30, F));
    localparam logic signed [ZW-1:0] Hp = ZW'(rte_pkg::from_q30(rte_pkg::HALF_PI_Q30, F));

    // global advance: the pipe moves unless a waiting result is stalled
    logic w_en;
    assign w_en        = !(o_valid && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    // tolerance register
    logic [rte_pkg::TOL_W-1:0] r_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_gimbal_tolerance;
        end
    end

    // input stage: lock decision and clamp of r31
    rte_pkg::t_side r_in, n_in;
    logic signed [17:0] w_a31, w_dev;
    always_comb begin
        w_a31 = (i_m31 < 0) ? -18'(i_m31) : 18'(i_m31);
        w_dev = w_a31 - 18'(rte_pkg::ONE_Q14);
        if (w_dev < 0) w_dev = -w_dev;
        n_in.valid   = i_valid;
        n_in.lock    = w_dev <= 18'(r_tol);
        n_in.m31_neg = i_m31 < 0;
        n_in.m11     = i_m11;
        n_in.m12     = i_m12;
        n_in.m13     = i_m13;
        n_in.m21     = i_m21;
        n_in.m32     = i_m32;
        n_in.m33     = i_m33;
        if (i_m31 > 16'(rte_pkg::ONE_Q14))       n_in.xc = 16'(rte_pkg::ONE_Q14);
        else if (i_m31 < -16'(rte_pkg::ONE_Q14)) n_in.xc = -16'(rte_pkg::ONE_Q14);
        else                                      n_in.xc = i_m31;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in <= '0;
        end else if (w_en) begin
            r_in <= n_in;
        end
    end

    // square root operand 1 - x^2 in q28
    logic [rte_pkg::SQ_N_W-1:0] r_n0;
    logic signed [31:0]         w_sq;
    assign w_sq = 32'(r_in.xc) * 32'(r_in.xc);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n0 <= rte_pkg::SQ_N_W'(29'h1000_0000 - w_sq[28:0]);
        end
    end

    // side operands ride beside the square root cells
    rte_pkg::t_side r_side [rte_pkg::SQ_CELLS+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= rte_pkg::SQ_CELLS; k++) r_side[k] <= '0;
        end else if (w_en) begin
            r_side[0] <= r_in;
            for (int k = 1; k <= rte_pkg::SQ_CELLS; k++) r_side[k] <= r_side[k-1];
        end
    end

    logic [rte_pkg::SQ_N_W-1:0] w_sn [rte_pkg::SQ_CELLS+1];
    logic [rte_pkg::SQ_R_W-1:0] w_sr [rte_pkg::SQ_CELLS+1];
    assign w_sn[0] = r_n0;
    assign w_sr[0] = '0;

    for (genvar k = 0; k < rte_pkg::SQ_CELLS; k++) begin : g_sqrt
        rte_isqrt_cell #(.K(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_n   (w_sn[k]),
            .i_r   (w_sr[k]),
            .o_n   (w_sn[k+1]),
            .o_r   (w_sr[k+1])
        );
    end

    // cordic chain arguments: asin, roll (or gimbal), folded roll, yaw, folded yaw
    rte_pkg::t_side w_s;
    logic signed [rte_pkg::ARG_W-1:0] w_ay [NCH];
    logic signed [rte_pkg::ARG_W-1:0] w_ax [NCH];
    always_comb begin
        w_s     = r_side[rte_pkg::SQ_CELLS];
        w_ay[0] = 17'(w_s.xc);
        w_ax[0] = 17'(w_sr[rte_pkg::SQ_CELLS][15:0]);
        w_ay[1] = w_s.lock ? 17'(w_s.m12) : 17'(w_s.m32);
        w_ax[1] = w_s.lock ? 17'(w_s.m13) : 17'(w_s.m33);
        w_ay[2] = -17'(w_s.m32);
        w_ax[2] = -17'(w_s.m33);
        w_ay[3] = 17'(w_s.m21);
        w_ax[3] = 17'(w_s.m11);
        w_ay[4] = -17'(w_s.m21);
        w_ax[4] = -17'(w_s.m11);
    end

    logic signed [XW-1:0] w_x     [NCH][CS+1];
    logic signed [XW-1:0] w_y     [NCH][CS+1];
    logic signed [ZW-1:0] w_z     [NCH][CS+1];
    logic                 w_spec  [NCH][CS+1];
    logic signed [ZW-1:0] w_spval [NCH][CS+1];

    for (genvar c = 0; c < NCH; c++) begin : g_chain
        rte_cordic_pre #(.F(F), .XW(XW), .ZW(ZW)) u_pre (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_y     (w_ay[c]),
            .i_x     (w_ax[c]),
            .o_x     (w_x[c][0]),
            .o_y     (w_y[c][0]),
            .o_z     (w_z[c][0]),
            .o_spec  (w_spec[c][0]),
            .o_spval (w_spval[c][0])
        );
        for (genvar j = 0; j < CS; j++) begin : g_cell
            rte_cordic_cell #(.S(j), .F(F), .XW(XW), .ZW(ZW)) u_cell (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_x     (w_x[c][j]),
                .i_y     (w_y[c][j]),
                .i_z     (w_z[c][j]),
                .i_spec  (w_spec[c][j]),
                .i_spval (w_spval[c][j]),
                .o_x     (w_x[c][j+1]),
                .o_y     (w_y[c][j+1]),
                .o_z     (w_z[c][j+1]),
                .o_spec  (w_spec[c][j+1]),
                .o_spval (w_spval[c][j+1])
            );
        end
    end

    // control rides beside the cordic cells, one slot per cell plus the fold
    rte_pkg::t_tail r_tail [CS+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CS; k++) r_tail[k] <= '0;
        end else if (w_en) begin
            r_tail[0] <= '{valid: w_s.valid, lock: w_s.lock, m31_neg: w_s.m31_neg};
            for (int k = 1; k <= CS; k++) r_tail[k] <= r_tail[k-1];
        end
    end

    // axis cases win, otherwise clamp the angle to +-pi
    function automatic logic signed [ZW-1:0] fin(logic spec, logic signed [ZW-1:0] spval,
                                                 logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] v;
        if (spec)         v = spval;
        else if (z > Pi)  v = Pi;
        else if (z < -Pi) v = -Pi;
        else              v = z;
        return v;
    endfunction

    function automatic logic signed [rte_pkg::OUT_W-1:0] sat(logic signed [ZW-1:0] z);
        logic signed [32:0] e;
        logic signed [rte_pkg::OUT_W-1:0] v;
        e = 33'(z);
        if (e > 33'sd32767)       v = 16'sh7fff;
        else if (e < -33'sd32768) v = 16'sh8000;
        else                      v = e[rte_pkg::OUT_W-1:0];
        return v;
    endfunction

    // candidate selection
    logic signed [ZW-1:0] w_t [NCH];
    logic signed [ZW-1:0] w_y1, w_y2, w_x1, w_x2, w_d, n_roll, n_pitch, n_yaw;
    logic signed [ZW:0]   w_ab1, w_ab2;
    logic                 w_neg2;
    rte_pkg::t_tail       w_tl;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_t[c] = fin(w_spec[c][CS], w_spval[c][CS], w_z[c][CS]);
        end
        w_tl   = r_tail[CS];
        w_y1   = -w_t[0];
        w_neg2 = w_y1 > 0;
        w_y2   = w_neg2 ? Pi - w_y1 : -w_y1;
        w_x1   = w_t[1];
        w_x2   = w_neg2 ? w_t[2] : w_x1;
        w_ab1  = (w_x1 < 0) ? -(ZW+1)'(w_x1) : (ZW+1)'(w_x1);
        w_ab2  = (w_x2 < 0) ? -(ZW+1)'(w_x2) : (ZW+1)'(w_x2);
        // gimbal: pi either way folds to zero
        w_d    = (w_t[1] == Pi || w_t[1] == -Pi) ? '0 : w_t[1];
        if (w_tl.lock) begin
            n_yaw   = '0;
            n_pitch = w_tl.m31_neg ? Hp : -Hp;
            n_roll  = w_tl.m31_neg ? w_d : -w_d;
        end else if (w_ab1 < w_ab2) begin
            n_pitch = w_y1;
            n_roll  = w_x1;
            n_yaw   = w_t[3];
        end else begin
            n_pitch = w_y2;
            n_roll  = w_x2;
            n_yaw   = w_neg2 ? w_t[4] : w_t[3];
        end
    end

    // output register
    logic r_ovalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= w_tl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_roll        <= sat(n_roll);
            o_pitch       <= sat(n_pitch);
            o_yaw         <= sat(n_yaw);
            o_gimbal_lock <= w_tl.lock;
        end
    end

    assign o_valid = r_ovalid;

    // a locked result has zero yaw
    a_lock_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gimbal_lock |-> o_yaw == '0)
        else $error("gimbal result with nonzero yaw");

    // a locked result has pitch at plus or minus half pi
    a_lock_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gimbal_lock |-> o_pitch == sat(Hp) || o_pitch == sat(-Hp))
        else $error("gimbal result with pitch off half pi");

    // a result appears only from a valid slot at the end of the chain
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_tail[CS].valid))
        else $error("result without a source transaction");

    // the input side is held exactly while a result waits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall out of step with output");

endmodule

### dv/rte_checker.sv
`timescale 1ns / 1ps
// result checker for rotation_matrix_to_euler_xyz: watches the input, config and output channels
// depends on rte_pkg; predicts roll, pitch, yaw and gimbal flag per matrix and compares

module rte_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_stall_in,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m11,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m12,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m13,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m21,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m31,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m32,
    input  logic signed [rte_pkg::IN_W-1:0]   i_m33,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [rte_pkg::OUT_W-1:0]  i_roll,
    input  logic signed [rte_pkg::OUT_W-1:0]  i_pitch,
    input  logic signed [rte_pkg::OUT_W-1:0]  i_yaw,
    input  logic                              i_gimbal_lock,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [rte_pkg::TOL_W-1:0]         i_cfg_tolerance,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_results,
    output int                                o_locks
);

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               lock;
    } t_euler;

    localparam longint FB = 13;
    localparam longint NSTG = 16;

    t_euler       angles_due[$];
    logic [10:0]  tol_q;

    function automatic longint q30_to_angle(longint q);
        return ((q >>> (29 - FB)) + 1) >>> 1;
    endfunction

    function automatic longint atan_step(int i);
        longint raw;
        case (i)
            0: raw = 843314856;   1: raw = 497837829;  2: raw = 263043836;
            3: raw = 133525158;   4: raw = 67021686;   5: raw = 33543515;
            6: raw = 16775850;    7: raw = 8388437;    8: raw = 4194282;
            9: raw = 2097149;     10: raw = 1048575;
            default: raw = (i <= 30) ? ((64'sd1 <<< (30 - i)) - 1) : 0;
        endcase
        return q30_to_angle(raw);
    endfunction

    function automatic longint vec_atan2(longint y, longint x);
        longint pi_a, hp, z, dx, dy;
        pi_a = q30_to_angle(64'sd3373259426);
        hp   = q30_to_angle(64'sd1686629713);
        z = 0;
        if (y == 0) return (x < 0) ? pi_a : 0;
        if (x == 0) return (y > 0) ? hp : -hp;
        if (x < 0) begin
            z = (y > 0) ? pi_a : -pi_a;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < NSTG; i++) begin
            dx = y >>> i;   // arithmetic shift is floor
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        if (z > pi_a) z = pi_a;
        if (z < -pi_a) z = -pi_a;
        return z;
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 30;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_euler predict_euler(longint m11, longint m12, longint m13,
                                             longint m21, longint m31, longint m32,
                                             longint m33, longint tol);
        longint pi_a, hp, dev, d, r, p, w, xc, y1, y2, x1, x2, ab1, ab2;
        logic   lk, flip;
        t_euler e;
        pi_a = q30_to_angle(64'sd3373259426);
        hp   = q30_to_angle(64'sd1686629713);
        dev = ((m31 < 0) ? -m31 : m31) - 16384;
        if (dev < 0) dev = -dev;
        lk = dev <= tol;
        if (lk) begin
            d = vec_atan2(m12, m13);
            if (d == pi_a || d == -pi_a) d = 0;
            w = 0;
            if (m31 < 0) begin p = hp; r = d; end
            else begin p = -hp; r = -d; end
        end else begin
            xc = m31;
            if (xc > 16384) xc = 16384;
            if (xc < -16384) xc = -16384;
            y1 = -vec_atan2(xc, floor_sqrt(16384 * 16384 - xc * xc));
            flip = y1 > 0;
            y2 = flip ? pi_a - y1 : -y1;
            x1 = vec_atan2(m32, m33);
            x2 = flip ? vec_atan2(-m32, -m33) : x1;
            ab1 = (x1 < 0) ? -x1 : x1;
            ab2 = (x2 < 0) ? -x2 : x2;
            if (ab1 < ab2) begin
                p = y1; r = x1; w = vec_atan2(m21, m11);
            end else begin
                p = y2; r = x2;
                w = flip ? vec_atan2(-m21, -m11) : vec_atan2(m21, m11);
            end
        end
        e.roll = clip16(r);
        e.pitch = clip16(p);
        e.yaw = clip16(w);
        e.lock = lk;
        return e;
    endfunction

    assign o_pending = angles_due.size();

    always @(posedge i_clk) begin
        t_euler e;
        if (!i_rst_n) begin
            tol_q <= '0;
            o_errors <= 0;
            o_results <= 0;
            o_locks <= 0;
            angles_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) tol_q <= i_cfg_tolerance;
            if (i_valid && !i_stall_in)
                angles_due.push_back(predict_euler(i_m11, i_m12, i_m13, i_m21, i_m31,
                                                   i_m32, i_m33, tol_q));
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (i_gimbal_lock) o_locks <= o_locks + 1;
                if (angles_due.size() == 0) begin
                    $error("result with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    e = angles_due.pop_front();
                    if (e.roll !== i_roll || e.pitch !== i_pitch || e.yaw !== i_yaw ||
                        e.lock !== i_gimbal_lock) begin
                        o_errors <= o_errors + 1;
                        if (e.roll !== i_roll)
                            $error("roll expected %0d got %0d", e.roll, i_roll);
                        if (e.pitch !== i_pitch)
                            $error("pitch expected %0d got %0d", e.pitch, i_pitch);
                        if (e.yaw !== i_yaw)
                            $error("yaw expected %0d got %0d", e.yaw, i_yaw);
                        if (e.lock !== i_gimbal_lock)
                            $error("gimbal_lock expected %0d got %0d", e.lock, i_gimbal_lock);
                    end
                end
            end
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// stimulus and verdict for rotation_matrix_to_euler_xyz
// depends on rte_pkg, the block and rte_checker

module testbench;

    // pipe depth of the block; the waits below add a margin to it
    localparam int LATENCY   = rte_pkg::DEF_CORDIC_STAGES + 19;
    localparam int CYC_LIMIT = 400000;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic signed [rte_pkg::IN_W-1:0] m11, m12, m13, m21, m31, m32, m33;
    logic signed [rte_pkg::OUT_W-1:0] o_roll, o_pitch, o_yaw;
    logic o_gimbal_lock, cfg_valid, cfg_ready;
    logic [rte_pkg::TOL_W-1:0] cfg_tol;
    int errors, pending, results, locks, items_sent;
    int cycles = 0;
    logic long_hold;   // forces a long receiver stall

    rotation_matrix_to_euler_xyz DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_m11(m11), .i_m12(m12), .i_m13(m13), .i_m21(m21),
        .i_m31(m31), .i_m32(m32), .i_m33(m33),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_roll(o_roll), .o_pitch(o_pitch), .o_yaw(o_yaw),
        .o_gimbal_lock(o_gimbal_lock),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_gimbal_tolerance(cfg_tol)
    );

    rte_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_m11(m11), .i_m12(m12), .i_m13(m13), .i_m21(m21),
        .i_m31(m31), .i_m32(m32), .i_m33(m33),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_roll(o_roll), .i_pitch(o_pitch), .i_yaw(o_yaw),
        .i_gimbal_lock(o_gimbal_lock),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_tolerance(cfg_tol),
        .o_errors(errors), .o_pending(pending),
        .o_results(results), .o_locks(locks)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog on total cycles
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // gap lengths: mostly zero or short, sometimes long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver stall: random, plus a forced hold-off window
    initial begin
        int g;
        i_stall = 0;
        @(negedge i_clk);
        forever begin
            if (long_hold) begin
                i_stall <= 1;
                @(negedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                i_stall <= (g != 0);
                repeat (g > 0 ? g : 1) @(negedge i_clk);
            end else begin
                i_stall <= 0;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // long hold-off while the sender keeps offering transactions
    initial begin
        long_hold = 0;
        wait (items_sent >= 150);
        @(negedge i_clk);
        long_hold = 1;
        repeat (120) @(negedge i_clk);
        long_hold = 0;
    end

    // drive one matrix and wait for it to be taken
    task automatic send_matrix(input logic signed [15:0] a11, a12, a13, a21, a31,
                               a32, a33, input bit idle_ok);
        int g;
        g = idle_ok ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1;
        m11 <= a11; m12 <= a12; m13 <= a13; m21 <= a21;
        m31 <= a31; m32 <= a32; m33 <= a33;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] entry_any();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom());   // full 16-bit range, beyond +-1 too
        if (r == 1) return 16'(int'($urandom_range(0, 4)) - 2);
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    // r31 near +-1 so the gimbal branch and its border get hit
    function automatic logic signed [15:0] r31_pick(int tol);
        int off;
        if ($urandom_range(0, 2) != 0) return entry_any();
        off = int'($urandom_range(0, 2 * tol + 4)) - tol - 2;
        return 16'($urandom_range(0, 1) ? 16384 + off : -16384 - off);
    endfunction

    task automatic drain_then_write(input logic [10:0] tol);
        i_valid <= 0;
        wait (pending == 0);
        repeat (LATENCY + 5) @(negedge i_clk);
        cfg_valid <= 1;
        cfg_tol <= tol;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 0;
    endtask

    initial begin
        logic [10:0] tol_set[5];
        logic signed [15:0] e[7];
        tol_set = '{11'd0, 11'd1024, 11'd2047, 11'd37, 11'd300};
        i_rst_n = 0; i_valid = 0; cfg_valid = 0; cfg_tol = 0;
        m11 = 0; m12 = 0; m13 = 0; m21 = 0; m31 = 0; m32 = 0; m33 = 0;
        items_sent = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: identity, axis cases, gimbal both sides, extremes
        send_matrix(16384, 0, 0, 0, 0, 0, 16384, 0);
        send_matrix(0, 0, 0, 0, 0, 0, 0, 0);                       // all zero
        send_matrix(-16384, 0, 0, 0, 0, 0, -16384, 0);             // x < 0 axis
        send_matrix(0, 0, 0, 16384, 0, 16384, 0, 0);               // y > 0 on axis
        send_matrix(0, 0, 0, -16384, 0, -16384, 0, 0);             // y < 0 on axis
        send_matrix(0, 16384, 0, 0, -16384, 0, 0, 0);              // gimbal, r31 negative
        send_matrix(0, 0, 16384, 0, 16384, 0, 0, 0);               // gimbal, r31 positive
        send_matrix(0, 0, -16384, 0, 16384, 0, 0, 0);              // gimbal roll at pi -> 0
        send_matrix(0, 0, -16384, 0, -16384, 0, 0, 0);
        send_matrix(0, 5, -16384, 0, 16384, 0, 0, 0);
        send_matrix(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                    16'sh7fff, 0);                                 // beyond +1, clamped
        send_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
        send_matrix(11585, 0, 0, 11585, -11585, 8192, -8192, 0);   // pitch positive
        send_matrix(11585, 0, 0, -11585, 11585, -8192, -8192, 0);  // r31 positive, pitch still positive
        send_matrix(100, 0, 0, 3, 16383, 7, -9, 0);                // just off the lock
        send_matrix(-100, 0, 0, -3, -16383, 7, 9, 0);
        send_matrix(1, 1, 1, 1, 1, 1, 1, 0);
        send_matrix(-1, -1, -1, -1, -1, -1, -1, 0);

        for (int ph = 0; ph < 5; ph++) begin
            drain_then_write(tol_set[ph]);
            // border of the tolerance window in this setting
            send_matrix(9, 10, -20, 0, 16'(16384 + int'(tol_set[ph])), 3, 4, 0);
            send_matrix(9, 10, -20, 0, 16'(-16384 - int'(tol_set[ph]) - 1), 3, 4, 0);
            for (int n = 0; n < 120; n++) begin
                for (int k = 0; k < 7; k++) e[k] = entry_any();
                e[4] = r31_pick(int'(tol_set[ph]));
                send_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6],
                            ($urandom_range(0, 3) != 0) && !(ph == 1 && n > 20 && n < 60));
            end
        end

        i_valid <= 0;
        wait (pending == 0);
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("covered %0d matrices, %0d results, %0d in gimbal lock, 5 tolerances",
                 items_sent, results, locks);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rte_pkg.sv
rtl/rte_isqrt_cell.sv
rtl/rte_cordic_pre.sv
rtl/rte_cordic_cell.sv
rtl/rotation_matrix_to_euler_xyz.sv
dv/rte_checker.sv
dv/testbench.sv
